@@ src/dpts_pkg.sv @@
`timescale 1ns / 1ps

package dpts_pkg;

    // default table depth
    localparam int DEF_MAX_SLOTS = 16;

    // field widths
    localparam int SLOT_W  = 4;
    localparam int PRIO_W  = 10;
    localparam int TIME_W  = 10;
    localparam int COUNT_W = 5;

    // stream widths
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 8;

    // configuration
    localparam int                 APB_DATA_W          = 32;
    localparam int                 APB_ADDR_W          = 3;
    localparam logic               REG_PROCESS_COUNT   = 1'b0;
    localparam logic [COUNT_W-1:0] PROCESS_COUNT_RESET = COUNT_W'(16);

    // saturation limits
    localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};
    localparam logic [TIME_W-1:0]        RAN_MAX  = '1;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    // one table row
    typedef struct packed {
        logic                      done;
        logic [TIME_W-1:0]         ran;
        logic [TIME_W-1:0]         need;
        logic [TIME_W-1:0]         arrival;
        logic signed [PRIO_W-1:0]  prio;
    } slot_entry_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic write_load;
        logic scan_read;
        logic write_update;
        logic load_out;
    } dpts_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last_slot;
        logic no_slots;
    } dpts_status_t;

endpackage

@@ src/dynamic_priority_tick_scheduler_unit.sv @@
`timescale 1ns / 1ps
// channel       | direction | contents
// s_axis        | in        | tuser: op; tdata: slot, priority_req, arrival, need_time, now
// m_axis        | out       | tuser: ran_valid; tdata: ran_slot, ran_finished, all_done
// apb           | in/out    | process_count at byte address 0
//
// a tick item passes through the scan, drain, update and result states; a load item first writes its row,
// and the scan reads used rows, where used is process_count saturated at MAX_SLOTS; with no slot in use
// the scan and drain are skipped. the scan reads one table row per cycle from the slot table.
// the next item can be taken in the same cycle that the result is offered.
// rst_n is asynchronous and clears the controller; the slot table is not cleared.
// a result waits in the output register; the next item is taken only once the
// previous result has been loaded there.

module dynamic_priority_tick_scheduler_unit
    import dpts_pkg::*;
#(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // slot, priority_req, arrival, need_time, now
    input  logic                  s_axis_tuser,  // op
    // result items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // ran_slot, ran_finished, all_done
    output logic                  m_axis_tuser,  // ran_valid
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [COUNT_W-1:0] process_count_reg;
    logic               cfg_write;
    dpts_cmd_t          cmd;
    dpts_status_t       status;
    logic               ran_valid;
    logic [SLOT_W-1:0]  ran_slot;
    logic               ran_finished;
    logic               all_done;

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_PROCESS_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            process_count_reg <= PROCESS_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            process_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_PROCESS_COUNT) ? APB_DATA_W'(process_count_reg) : '0;

    dpts_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_op    (s_axis_tuser),
        .s_ready (s_axis_tready),
        .m_ready (m_axis_tready),
        .m_valid (m_axis_tvalid),
        .cmd     (cmd),
        .status  (status)
    );

    dpts_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .process_count   (process_count_reg),
        .in_op           (s_axis_tuser),
        .in_slot         (s_axis_tdata[3:0]),
        .in_priority_req (s_axis_tdata[13:4]),
        .in_arrival      (s_axis_tdata[23:14]),
        .in_need_time    (s_axis_tdata[33:24]),
        .in_now          (s_axis_tdata[43:34]),
        .ran_valid       (ran_valid),
        .ran_slot        (ran_slot),
        .ran_finished    (ran_finished),
        .all_done        (all_done)
    );

    // result packing
    assign m_axis_tuser = ran_valid;
    assign m_axis_tdata = {2'b00, all_done, ran_finished, ran_slot};

endmodule

@@ src/dpts_ram.sv @@
`timescale 1ns / 1ps

module dpts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/dpts_dp.sv @@
`timescale 1ns / 1ps

module dpts_dp
    import dpts_pkg::*;
#(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  dpts_cmd_t                cmd,
    output dpts_status_t             status,
    input  logic [COUNT_W-1:0]       process_count,
    input  logic                     in_op,
    input  logic [SLOT_W-1:0]        in_slot,
    input  logic signed [PRIO_W-1:0] in_priority_req,
    input  logic [TIME_W-1:0]        in_arrival,
    input  logic [TIME_W-1:0]        in_need_time,
    input  logic [TIME_W-1:0]        in_now,
    output logic                     ran_valid,
    output logic [SLOT_W-1:0]        ran_slot,
    output logic                     ran_finished,
    output logic                     all_done
);

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int EW = $bits(slot_entry_t);

    // captured item
    logic                     op_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic signed [PRIO_W-1:0] prio_reg;
    logic [TIME_W-1:0]        arrival_reg;
    logic [TIME_W-1:0]        need_reg;
    logic [TIME_W-1:0]        now_reg;

    // scan state
    logic [IW-1:0] idx_reg;
    logic          rd_pend_reg;
    logic [IW-1:0] rd_idx_reg;
    logic          best_valid_reg;
    logic [IW-1:0] best_idx_reg;
    slot_entry_t   best_entry_reg;
    logic [CW-1:0] notdone_reg;

    // result register
    logic              res_valid_reg;
    logic [SLOT_W-1:0] res_slot_reg;
    logic              res_fin_reg;
    logic              res_all_reg;

    logic [CW-1:0]     used;
    logic [EW-1:0]     rdata;
    slot_entry_t       rd_entry;
    slot_entry_t       load_entry;
    slot_entry_t       upd_entry;
    logic [TIME_W-1:0] ran_new;
    logic              fin;
    logic              take;
    logic              slot_ok;
    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    slot_entry_t       ram_wdata;
    logic              all_done_next;

    // slots in use, saturated at the table depth
    assign used = (32'(process_count) > MAX_SLOTS) ? CW'(MAX_SLOTS) : CW'(process_count);

    assign status.no_slots  = (used == '0);
    assign status.last_slot = ((CW'(idx_reg) + CW'(1)) == used);

    // candidate test on the row just read
    assign rd_entry = slot_entry_t'(rdata);
    assign take = rd_pend_reg && (op_reg == OP_TICK) && !rd_entry.done
                  && (rd_entry.arrival <= now_reg)
                  && (!best_valid_reg || ($signed(rd_entry.prio) > $signed(best_entry_reg.prio)));

    // row written by a load item, need clamped to one
    always_comb
    begin
        load_entry.done    = 1'b0;
        load_entry.ran     = '0;
        load_entry.need    = (need_reg == '0) ? TIME_W'(1) : need_reg;
        load_entry.arrival = arrival_reg;
        load_entry.prio    = prio_reg;
    end

    // row written back for the slot that ran
    always_comb
    begin
        ran_new = (best_entry_reg.ran == RAN_MAX) ? best_entry_reg.ran
                                                  : best_entry_reg.ran + TIME_W'(1);
        fin = (ran_new >= best_entry_reg.need);
        upd_entry.done    = fin;
        upd_entry.ran     = ran_new;
        upd_entry.need    = best_entry_reg.need;
        upd_entry.arrival = best_entry_reg.arrival;
        upd_entry.prio    = (best_entry_reg.prio == PRIO_MIN) ? best_entry_reg.prio
                                                              : best_entry_reg.prio - PRIO_W'(1);
    end

    assign slot_ok   = (32'(slot_reg) < MAX_SLOTS);
    assign ram_we    = (cmd.write_load && slot_ok) || (cmd.write_update && best_valid_reg);
    assign ram_waddr = cmd.write_load ? IW'(slot_reg) : best_idx_reg;
    assign ram_wdata = cmd.write_load ? load_entry : upd_entry;

    // every slot in use done once the chosen slot is updated
    assign all_done_next = (notdone_reg == '0)
                           || ((notdone_reg == CW'(1)) && best_valid_reg && fin);

    dpts_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg      <= in_op;
            slot_reg    <= in_slot;
            prio_reg    <= in_priority_req;
            arrival_reg <= in_arrival;
            need_reg    <= in_need_time;
            now_reg     <= in_now;
        end
    end

    // scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            best_valid_reg <= 1'b0;
            notdone_reg    <= '0;
        end
        else
        begin
            rd_pend_reg <= cmd.scan_read;
            if (cmd.start)
            begin
                idx_reg        <= '0;
                best_valid_reg <= 1'b0;
                notdone_reg    <= '0;
            end
            else
            begin
                if (cmd.scan_read)
                begin
                    idx_reg <= idx_reg + IW'(1);
                end
                if (take)
                begin
                    best_valid_reg <= 1'b1;
                end
                if (rd_pend_reg && !rd_entry.done)
                begin
                    notdone_reg <= notdone_reg + CW'(1);
                end
            end
        end
    end

    // best row so far and read index pipeline
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= idx_reg;
        if (take)
        begin
            best_idx_reg   <= rd_idx_reg;
            best_entry_reg <= rd_entry;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            res_valid_reg <= best_valid_reg;
            res_slot_reg  <= best_valid_reg ? SLOT_W'(best_idx_reg) : '0;
            res_fin_reg   <= best_valid_reg && fin;
            res_all_reg   <= all_done_next;
        end
    end

    assign ran_valid    = res_valid_reg;
    assign ran_slot     = res_slot_reg;
    assign ran_finished = res_fin_reg;
    assign all_done     = res_all_reg;

endmodule

@@ src/dpts_ctrl.sv @@
`timescale 1ns / 1ps

module dpts_ctrl
    import dpts_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_valid,
    input  logic         s_op,
    output logic         s_ready,
    input  logic         m_ready,
    output logic         m_valid,
    output dpts_cmd_t    cmd,
    input  dpts_status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE,
        ST_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   accept;
    logic   out_free;

    assign accept   = s_valid && (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_op == OP_LOAD)
                    begin
                        state_next = ST_WRITE;
                    end
                    else if (status.no_slots)
                    begin
                        state_next = ST_UPDATE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_WRITE:
            begin
                state_next = status.no_slots ? ST_UPDATE : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (status.last_slot)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if ((state_reg == ST_RESULT) && out_free)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath commands
    assign cmd.start        = accept;
    assign cmd.write_load   = (state_reg == ST_WRITE);
    assign cmd.scan_read    = (state_reg == ST_SCAN);
    assign cmd.write_update = (state_reg == ST_UPDATE);
    assign cmd.load_out     = (state_reg == ST_RESULT) && out_free;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

@@ src/dpts_checker.sv @@
`timescale 1ns / 1ps

module dpts_checker
    import dpts_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser
);

    // an idle or load result names no slot and no completion
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[4:0] == '0))
        else $error("idle result carries a slot or completion");

    // the block works on one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after an accepted item");

    // a result never appears the cycle after an item is taken
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid))
        else $error("result raised too soon after acceptance");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind dynamic_priority_tick_scheduler_unit dpts_checker u_dpts_checker (.*);
